// File: design/bar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bar_pkg
// Shared types and constants for the button auto-repeat unit.
// ----------------------------------------------------------------------------
package bar_pkg;

    localparam int PAD_W       = 16;
    localparam int DELAY_W     = 8;
    localparam int COUNT_W     = 9;
    localparam int GROUP_W     = 4;
    localparam int CFG_INDEX_W = 2;

    localparam logic [PAD_W-1:0] FACE_MASK = 16'hF000;
    localparam logic [PAD_W-1:0] NAV_MASK  = 16'h08E0;

    localparam logic [DELAY_W-1:0] FIRST_DELAY_RESET     = 8'd12;
    localparam logic [DELAY_W-1:0] REPEAT_INTERVAL_RESET = 8'd5;

    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_DELAY     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_INTERVAL = 2'd1;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_FACE = 2'd1,
        MODE_NAV  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [DELAY_W-1:0] first_delay;
        logic [DELAY_W-1:0] repeat_interval;
    } delay_cfg_t;

endpackage

// File: design/button_auto_repeat_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_auto_repeat_unit
// Delayed auto-shift repeat for a 16-bit pad word, one result word per frame.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   input   | in_valid, in_ready, pad_bits          | in
//   output  | out_valid, out_ready, triggered_buttons| out
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// Path from input accept to result: the input register, then the state
// update into the result register. One word per cycle when not stalled.
// Reset puts the mode in idle, clears counters and loads both delays.
// A stalled output holds the result and the input register; input stays
// ready while either stage can advance. Config writes complete every cycle.
// ----------------------------------------------------------------------------
module button_auto_repeat_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [bar_pkg::PAD_W-1:0]        pad_bits,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [bar_pkg::PAD_W-1:0]        triggered_buttons,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bar_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bar_pkg::DELAY_W-1:0]      cfg_data
);
    import bar_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    logic [PAD_W-1:0]  pad_reg;
    logic              out_valid_reg, out_valid_next;
    logic [PAD_W-1:0]  result_reg;
    logic              s1_adv, step;
    logic [PAD_W-1:0]  report;
    delay_cfg_t        delays;

    assign cfg_ready = 1'b1;

    bar_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .delays   (delays)
    );

    bar_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .pad    (pad_reg),
        .delays (delays),
        .report (report)
    );

    assign s1_adv   = !out_valid_reg || out_ready;
    assign step     = s1_valid_reg && s1_adv;
    assign in_ready = !s1_valid_reg || s1_adv;

    assign s1_valid_next  = (in_valid && in_ready) || (s1_valid_reg && !s1_adv);
    assign out_valid_next = step || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold payloads while stalled
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            pad_reg <= pad_bits;
        if (step)
            result_reg <= report;
    end

    assign out_valid         = out_valid_reg;
    assign triggered_buttons = result_reg;

`ifndef SYNTHESIS
    a_report_in_masks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((triggered_buttons & ~(FACE_MASK | NAV_MASK)) == '0))
        else $error("result word has bits outside the button groups");

    a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid)
        else $error("processed word did not reach the output register");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid && !out_ready) |=> (s1_valid_reg && $stable(pad_reg)))
        else $error("input stage lost a word under output stall");
`endif

endmodule

// File: design/bar_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bar_cfg
// Delay register file: first delay and repeat interval.
// ----------------------------------------------------------------------------
module bar_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [bar_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  logic [bar_pkg::DELAY_W-1:0]      wr_data,
    output bar_pkg::delay_cfg_t              delays
);
    import bar_pkg::*;

    delay_cfg_t delays_reg;
    delay_cfg_t delays_next;

    always_comb
    begin
        delays_next = delays_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_FIRST_DELAY:     delays_next.first_delay     = wr_data;
                CFG_REPEAT_INTERVAL: delays_next.repeat_interval = wr_data;
                default:             delays_next = delays_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delays_reg.first_delay     <= FIRST_DELAY_RESET;
            delays_reg.repeat_interval <= REPEAT_INTERVAL_RESET;
        end
        else
        begin
            delays_reg <= delays_next;
        end
    end

    assign delays = delays_reg;

endmodule

// File: design/bar_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bar_core
// Repeat state machine: mode, per-group counters, limits and last-frame bits.
// ----------------------------------------------------------------------------
module bar_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [bar_pkg::PAD_W-1:0]   pad,
    input  bar_pkg::delay_cfg_t         delays,
    output logic [bar_pkg::PAD_W-1:0]   report
);
    import bar_pkg::*;

    mode_t                mode_reg, mode_next, mode_eff;
    logic [COUNT_W-1:0]   face_count_reg, face_count_next;
    logic [COUNT_W-1:0]   nav_count_reg, nav_count_next;
    logic [DELAY_W-1:0]   face_limit_reg, face_limit_next;
    logic [DELAY_W-1:0]   nav_limit_reg, nav_limit_next;
    logic [GROUP_W-1:0]   face_seen_reg, face_seen_next;
    logic [GROUP_W-1:0]   nav_seen_reg, nav_seen_next;

    logic [PAD_W-1:0]     face_now, nav_now;
    logic                 face_start, nav_start;
    logic                 face_hit, nav_hit, face_fire, nav_fire;
    logic [COUNT_W-1:0]   face_base, nav_base, face_inc, nav_inc;
    logic [DELAY_W-1:0]   face_lim, nav_lim;

    assign face_now       = pad & FACE_MASK;
    assign nav_now        = pad & NAV_MASK;
    assign face_seen_next = pad[15:12];
    assign nav_seen_next  = {pad[11], pad[7:5]};

    // next state
    always_comb
    begin
        mode_eff   = ((face_now | nav_now) == '0) ? MODE_IDLE : mode_reg;
        face_start = (mode_eff == MODE_IDLE) && (face_now != '0);
        nav_start  = (mode_eff == MODE_IDLE) && (nav_now != '0);
        if (nav_start)
            mode_next = MODE_NAV;
        else if (face_start)
            mode_next = MODE_FACE;
        else
            mode_next = mode_eff;
    end

    // outputs and group datapath
    always_comb
    begin
        face_base = face_start ? '0 : face_count_reg;
        nav_base  = nav_start  ? '0 : nav_count_reg;
        face_lim  = face_start ? delays.first_delay : face_limit_reg;
        nav_lim   = nav_start  ? delays.first_delay : nav_limit_reg;
        face_inc  = face_base + COUNT_W'(1);
        nav_inc   = nav_base + COUNT_W'(1);

        face_hit  = (mode_next == MODE_FACE) && ((face_seen_next & face_seen_reg) != '0);
        nav_hit   = (mode_next == MODE_NAV) && ((nav_seen_next & nav_seen_reg) != '0);
        face_fire = face_hit && (face_inc > {1'b0, face_lim});
        nav_fire  = nav_hit && (nav_inc > {1'b0, nav_lim});

        face_count_next = face_fire ? '0 : (face_hit ? face_inc : face_base);
        nav_count_next  = nav_fire  ? '0 : (nav_hit  ? nav_inc  : nav_base);
        face_limit_next = face_fire ? delays.repeat_interval : face_lim;
        nav_limit_next  = nav_fire  ? delays.repeat_interval : nav_lim;

        report = '0;
        if (face_start || face_fire)
            report = report | face_now;
        if (nav_fire)
            report = report | nav_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            face_count_reg <= '0;
            nav_count_reg  <= '0;
            face_limit_reg <= FIRST_DELAY_RESET;
            nav_limit_reg  <= FIRST_DELAY_RESET;
            face_seen_reg  <= '0;
            nav_seen_reg   <= '0;
        end
        else if (step)
        begin
            mode_reg       <= mode_next;
            face_count_reg <= face_count_next;
            nav_count_reg  <= nav_count_next;
            face_limit_reg <= face_limit_next;
            nav_limit_reg  <= nav_limit_next;
            face_seen_reg  <= face_seen_next;
            nav_seen_reg   <= nav_seen_next;
        end
    end

endmodule
